[src/tlssni_pkg.sv]
// tlssni_pkg: shared types and constants of the client hello server name extractor
// used by every module under src; no dependencies of its own

package tlssni_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_HS_TYPE   = 2'd0;
   localparam logic [1:0] REG_MAX_MINOR = 2'd1;
   localparam logic [1:0] REG_MAX_NAME  = 2'd2;

   localparam logic [7:0] RST_HS_TYPE   = 8'd22;
   localparam logic [7:0] RST_MAX_MINOR = 8'd4;
   localparam logic [7:0] RST_MAX_NAME  = 8'd255;

   // fixed part of the hello: record header, handshake header, version, random, sid length
   localparam logic [5:0] OFS_REC_TYPE  = 6'd0;
   localparam logic [5:0] OFS_VER_MAJOR = 6'd9;
   localparam logic [5:0] OFS_VER_MINOR = 6'd10;
   localparam logic [5:0] OFS_SID_LEN   = 6'd43;

   localparam logic [7:0]  TLS_MAJOR       = 8'd3;
   localparam logic [15:0] EXT_SERVER_NAME = 16'd0;

   // header byte indexes and header byte count inside the server name extension
   localparam logic [2:0] SNI_NAME_LEN_HI = 3'd3;
   localparam logic [2:0] SNI_NAME_LEN_LO = 3'd4;
   localparam logic [2:0] SNI_HDR_BYTES   = 3'd5;

   localparam logic [7:0] NAME_CNT_MAX = 8'd255;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_NOT_HS    = 3'd2,
      ST_BAD_VER   = 3'd3,
      ST_TRUNC     = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] hs_type;
      logic [7:0] max_minor;
      logic [7:0] max_name;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] name_byte;
      logic       has_name;
      status_type status;
      logic       final_item;
   } rsp_item_type;

endpackage

[src/tlssni_csr.sv]
// tlssni_csr: apb-style configuration registers of the extractor
// depends on tlssni_pkg for register indexes and reset values

module tlssni_csr
   import tlssni_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] index;
   logic       wr_en;

   assign pready = 1'b1;
   assign index  = paddr[3:2];
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_HS_TYPE:   cfg_in.hs_type   = pwdata[7:0];
            REG_MAX_MINOR: cfg_in.max_minor = pwdata[7:0];
            REG_MAX_NAME:  cfg_in.max_name  = pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_HS_TYPE:   prdata = {24'd0, cfg_ff.hs_type};
         REG_MAX_MINOR: prdata = {24'd0, cfg_ff.max_minor};
         REG_MAX_NAME:  prdata = {24'd0, cfg_ff.max_name};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hs_type   <= RST_HS_TYPE;
         cfg_ff.max_minor <= RST_MAX_MINOR;
         cfg_ff.max_name  <= RST_MAX_NAME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/tlssni_parser.sv]
// tlssni_parser: walks the client hello one byte per advance and forms the result item
// depends on tlssni_pkg for config, status and result types

module tlssni_parser
   import tlssni_pkg::*;
#(
   parameter int LENGTH_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic [7:0]   item_byte,
   input  logic         item_last,
   input  logic         advance,
   output rsp_item_type rsp
);

   localparam int LB = LENGTH_BITS;

   typedef enum logic [3:0] {
      PH_FIXED, PH_SID, PH_CS_HI, PH_CS_LO, PH_CS_BODY, PH_CM_LEN, PH_CM_BODY,
      PH_EXT_HI, PH_EXT_LO, PH_TYPE_HI, PH_TYPE_LO, PH_ELEN_HI, PH_ELEN_LO,
      PH_EXT_BODY, PH_SNI, PH_TERM
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [5:0] offset_ff, offset_in;
   logic [7:0] hi_ff, hi_in;
   logic [LB-1:0] field_ff, field_in;
   logic [LB-1:0] ext_ff, ext_in;
   logic [LB-1:0] name_rem_ff, name_rem_in;
   logic       type_sni_ff, type_sni_in;
   logic [2:0] sni_cnt_ff, sni_cnt_in;
   logic [7:0] emitted_ff, emitted_in;
   status_type status_ff, status_in;
   logic       done_ff, done_in;

   logic [15:0]   len16;
   logic [LB-1:0] wire_len;
   logic [LB-1:0] field_dec, ext_dec, name_dec;
   logic          emit;

   assign len16 = {hi_ff, item_byte};

   // two-byte wire length, saturated to the counter width
   if (LB >= 16) begin : g_wide
      assign wire_len = LB'(len16);
   end else begin : g_narrow
      assign wire_len = (|(len16 >> LB)) ? '1 : len16[LB-1:0];
   end

   assign field_dec = (field_ff != '0) ? field_ff - 1'b1 : '0;
   assign ext_dec   = (ext_ff != '0) ? ext_ff - 1'b1 : '0;
   assign name_dec  = (name_rem_ff != '0) ? name_rem_ff - 1'b1 : '0;

   always_comb begin
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      hi_in       = hi_ff;
      field_in    = field_ff;
      ext_in      = ext_ff;
      name_rem_in = name_rem_ff;
      type_sni_in = type_sni_ff;
      sni_cnt_in  = sni_cnt_ff;
      emitted_in  = emitted_ff;
      status_in   = status_ff;
      done_in     = done_ff;
      emit        = 1'b0;

      unique case (phase_ff)
         PH_FIXED: begin
            offset_in = offset_ff + 1'b1;
            if (offset_ff == OFS_VER_MAJOR) begin
               hi_in = item_byte;
            end
            if (offset_ff == OFS_REC_TYPE && item_byte != cfg.hs_type) begin
               phase_in  = PH_TERM;
               status_in = ST_NOT_HS;
               done_in   = 1'b1;
            end else if (offset_ff == OFS_VER_MINOR &&
                         (hi_ff != TLS_MAJOR || item_byte > cfg.max_minor)) begin
               phase_in  = PH_TERM;
               status_in = ST_BAD_VER;
               done_in   = 1'b1;
            end else if (offset_ff == OFS_SID_LEN) begin
               field_in = LB'(item_byte);
               phase_in = (item_byte != 8'd0) ? PH_SID : PH_CS_HI;
            end
         end
         PH_SID: begin
            field_in = field_dec;
            if (field_dec == '0) phase_in = PH_CS_HI;
         end
         PH_CS_HI: begin
            hi_in    = item_byte;
            phase_in = PH_CS_LO;
         end
         PH_CS_LO: begin
            field_in = wire_len;
            phase_in = (wire_len != '0) ? PH_CS_BODY : PH_CM_LEN;
         end
         PH_CS_BODY: begin
            field_in = field_dec;
            if (field_dec == '0) phase_in = PH_CM_LEN;
         end
         PH_CM_LEN: begin
            field_in = LB'(item_byte);
            phase_in = (item_byte != 8'd0) ? PH_CM_BODY : PH_EXT_HI;
         end
         PH_CM_BODY: begin
            field_in = field_dec;
            if (field_dec == '0) phase_in = PH_EXT_HI;
         end
         PH_EXT_HI: begin
            hi_in    = item_byte;
            phase_in = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            ext_in = wire_len;
            if (wire_len == '0) begin
               phase_in  = PH_TERM;
               status_in = ST_NOT_FOUND;
               done_in   = 1'b1;
            end else begin
               phase_in = PH_TYPE_HI;
            end
         end
         PH_TYPE_HI: begin
            hi_in    = item_byte;
            ext_in   = ext_dec;
            phase_in = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            type_sni_in = (len16 == EXT_SERVER_NAME);
            ext_in      = ext_dec;
            phase_in    = PH_ELEN_HI;
         end
         PH_ELEN_HI: begin
            hi_in    = item_byte;
            ext_in   = ext_dec;
            phase_in = PH_ELEN_LO;
         end
         PH_ELEN_LO: begin
            field_in = wire_len;
            ext_in   = ext_dec;
            if (wire_len == '0) begin
               // empty extension body: straight to the next boundary
               if (ext_dec == '0) begin
                  phase_in  = PH_TERM;
                  status_in = ST_NOT_FOUND;
                  done_in   = 1'b1;
               end else begin
                  phase_in = PH_TYPE_HI;
               end
            end else if (type_sni_ff) begin
               phase_in   = PH_SNI;
               sni_cnt_in = 3'd0;
            end else begin
               phase_in = PH_EXT_BODY;
            end
         end
         PH_EXT_BODY: begin
            field_in = field_dec;
            ext_in   = ext_dec;
            if (field_dec == '0) begin
               if (ext_dec == '0) begin
                  phase_in  = PH_TERM;
                  status_in = ST_NOT_FOUND;
                  done_in   = 1'b1;
               end else begin
                  phase_in = PH_TYPE_HI;
               end
            end
         end
         PH_SNI: begin
            if (sni_cnt_ff < SNI_HDR_BYTES) begin
               sni_cnt_in = sni_cnt_ff + 1'b1;
               if (sni_cnt_ff == SNI_NAME_LEN_HI) begin
                  hi_in = item_byte;
               end
               if (sni_cnt_ff == SNI_NAME_LEN_LO) begin
                  name_rem_in = wire_len;
                  if (wire_len == '0) begin
                     sni_cnt_in = sni_cnt_ff;
                     phase_in   = PH_TERM;
                     status_in  = ST_FOUND;
                     done_in    = 1'b1;
                  end
               end
            end else begin
               emit        = (emitted_ff < cfg.max_name);
               emitted_in  = (emitted_ff < NAME_CNT_MAX) ? emitted_ff + 1'b1 : emitted_ff;
               name_rem_in = name_dec;
               if (name_dec == '0) begin
                  phase_in  = PH_TERM;
                  status_in = ST_FOUND;
                  done_in   = 1'b1;
               end
            end
         end
         PH_TERM: begin
            // trailing bytes are ignored until end of record
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.valid      = emit || item_last;
      rsp.name_byte  = emit ? item_byte : 8'd0;
      rsp.has_name   = emit;
      rsp.final_item = item_last;
      if (!item_last) begin
         rsp.status = ST_FOUND;
      end else if (done_in) begin
         rsp.status = status_in;
      end else begin
         rsp.status = ST_TRUNC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item_last)) begin
         phase_ff    <= PH_FIXED;
         offset_ff   <= '0;
         hi_ff       <= '0;
         field_ff    <= '0;
         ext_ff      <= '0;
         name_rem_ff <= '0;
         type_sni_ff <= 1'b0;
         sni_cnt_ff  <= '0;
         emitted_ff  <= '0;
         status_ff   <= ST_FOUND;
         done_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         hi_ff       <= hi_in;
         field_ff    <= field_in;
         ext_ff      <= ext_in;
         name_rem_ff <= name_rem_in;
         type_sni_ff <= type_sni_in;
         sni_cnt_ff  <= sni_cnt_in;
         emitted_ff  <= emitted_in;
         status_ff   <= status_in;
         done_ff     <= done_in;
      end
   end

   a_done_iff_term: assert property (@(posedge clock) disable iff (reset)
      done_ff == (phase_ff == PH_TERM))
      else $error("record done flag out of step with parse phase");

   a_emit_in_name: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == PH_SNI && sni_cnt_ff == SNI_HDR_BYTES))
      else $error("name byte emitted outside the name body");

   a_emit_limit: assert property (@(posedge clock) disable iff (reset)
      emit |-> emitted_ff < cfg.max_name)
      else $error("name byte emitted past the configured limit");

endmodule

[src/tls_client_hello_sni_extractor.sv]
// tls_client_hello_sni_extractor: top level with request register, parser and result register
// depends on tlssni_pkg, tlssni_csr and tlssni_parser

// Takes a TLS record one byte per request (tlast on the last byte) and walks the
// ClientHello layout, skipping each element by its length field. Bytes of the host
// name in the first server_name extension come out one per result, cut off at
// max_name_len; the byte with tlast always yields one final result carrying the
// status (found, not found, not handshake, bad version, truncated), merged with a
// name byte if one falls on it. One byte is taken every cycle while results are taken:
// the request register feeds a single pass of counter and compare logic into the result
// register. Lengths from the wire saturate at LENGTH_BITS bits. Configuration must be
// written over the csr port while no request is in flight; the block itself does not
// enforce this.

module tls_client_hello_sni_extractor
   import tlssni_pkg::*;
#(
   parameter int LENGTH_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] record_byte
   input  logic        req_tlast,   // end_of_record
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] name_byte
   output logic        rsp_tlast,   // final_item
   output logic [3:0]  rsp_tuser,   // [0] has_name_byte, [3:1] result_status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type      cfg;
   rsp_item_type rsp_item;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_has_ff;
   status_type out_status_ff;
   logic       out_last_ff;

   logic out_free;
   logic advance;
   logic req_take;

   tlssni_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tlssni_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_byte (s1_byte_ff),
      .item_last (s1_last_ff),
      .advance   (advance),
      .rsp       (rsp_item)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   // a byte that yields no result never waits on the result side
   assign advance    = s1_valid_ff && (!rsp_item.valid || out_free);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = out_free ? (advance && rsp_item.valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (out_free && advance && rsp_item.valid) begin
         out_byte_ff   <= rsp_item.name_byte;
         out_has_ff    <= rsp_item.has_name;
         out_status_ff <= rsp_item.status;
         out_last_ff   <= rsp_item.final_item;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_status_ff, out_has_ff};

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("pending request dropped without being parsed");

   a_take_when_full: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && s1_valid_ff |-> advance)
      else $error("request taken over one still pending");

   a_nonfinal_has_name: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[0] && rsp_tuser[3:1] == ST_FOUND)
      else $error("non-final result without a name byte");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3:1] <= ST_TRUNC)
      else $error("result status out of range");

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for the client hello server name extractor
// drives records byte by byte, predicts every result and compares on the fly
// depends on tlssni_pkg and tls_client_hello_sni_extractor
`timescale 1ns / 1ps

module testbench;
   import tlssni_pkg::*;

   typedef enum logic [3:0] {
      PH_FIXED, PH_SID, PH_CS_HI, PH_CS_LO, PH_CS_BODY, PH_CM_LEN, PH_CM_BODY,
      PH_EXT_HI, PH_EXT_LO, PH_TYPE_HI, PH_TYPE_LO, PH_ELEN_HI, PH_ELEN_LO,
      PH_EXT_BODY, PH_SNI, PH_DONE
   } hello_phase_t;

   typedef struct {
      logic [7:0] name_byte;
      logic       has_name;
      status_type status;
      logic       final_item;
   } sni_result_t;

   // shape of one generated client hello record
   typedef struct {
      logic [7:0] rec_type, ver_major, ver_minor, name_type;
      int sid_len, cs_len, cm_len, n_before, n_after, name_len, trailing, cut, ext_len;
      bit zero_sni, has_sni;
   } hello_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] record_byte
   logic        req_tlast;   // end_of_record
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] name_byte
   logic        rsp_tlast;   // final_item
   logic [3:0]  rsp_tuser;   // [0] has_name_byte, [3:1] result_status
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tls_client_hello_sni_extractor i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sni_result_t pending_sni_results[$];
   int mismatch_count = 0;
   int requests_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   // predictor copy of the registers and the parser state
   logic [7:0]   cfg_hs_type, cfg_max_minor, cfg_max_name;
   hello_phase_t phase;
   logic [15:0]  ofs, fld_left, ext_left, ext_acc, name_left;
   logic [7:0]   name_cnt;
   logic         done;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tls_client_hello_sni_extractor: mismatch");
      $finish;
   end

   function automatic void clear_record_state();
      ofs = '0;
      phase = PH_FIXED;
      fld_left = '0;
      ext_left = '0;
      ext_acc = '0;
      name_left = '0;
      name_cnt = '0;
      done = 1'b0;
   endfunction

   function automatic logic [15:0] count_down(logic [15:0] v);
      return (v != 0) ? v - 16'd1 : 16'd0;
   endfunction

   function automatic void end_parse(status_type s);
      phase = PH_DONE;
      ext_acc = {13'd0, s};
      done = 1'b1;
   endfunction

   function automatic void next_extension();
      if (ext_left == 0) end_parse(ST_NOT_FOUND);
      else phase = PH_TYPE_HI;
   endfunction

   // lengths are 16 bits wide, so two wire bytes never exceed the saturation limit
   function automatic void predict_sni_step(logic [7:0] b, logic last);
      logic emit;
      sni_result_t r;
      emit = 1'b0;
      case (phase)
         PH_FIXED: begin
            if (ofs == OFS_REC_TYPE && b != cfg_hs_type) begin
               end_parse(ST_NOT_HS);
            end else if (ofs == OFS_VER_MINOR && (ext_acc != TLS_MAJOR || b > cfg_max_minor)) begin
               end_parse(ST_BAD_VER);
            end else begin
               if (ofs == OFS_VER_MAJOR) ext_acc = {8'h00, b};
               if (ofs == OFS_SID_LEN) begin
                  fld_left = {8'h00, b};
                  ext_acc = '0;
                  phase = (b != 0) ? PH_SID : PH_CS_HI;
               end
               if (ofs != 16'hFFFF) ofs = ofs + 16'd1;
            end
         end
         PH_SID: begin
            fld_left = count_down(fld_left);
            if (fld_left == 0) phase = PH_CS_HI;
         end
         PH_CS_HI: begin
            fld_left = {b, 8'h00};
            phase = PH_CS_LO;
         end
         PH_CS_LO: begin
            fld_left = {fld_left[15:8], b};
            phase = (fld_left != 0) ? PH_CS_BODY : PH_CM_LEN;
         end
         PH_CS_BODY: begin
            fld_left = count_down(fld_left);
            if (fld_left == 0) phase = PH_CM_LEN;
         end
         PH_CM_LEN: begin
            fld_left = {8'h00, b};
            phase = (b != 0) ? PH_CM_BODY : PH_EXT_HI;
         end
         PH_CM_BODY: begin
            fld_left = count_down(fld_left);
            if (fld_left == 0) phase = PH_EXT_HI;
         end
         PH_EXT_HI: begin
            ext_left = {b, 8'h00};
            phase = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            ext_left = {ext_left[15:8], b};
            next_extension();
         end
         PH_TYPE_HI: begin
            ext_acc = {b, 8'h00};
            ext_left = count_down(ext_left);
            phase = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            ext_acc = {ext_acc[15:8], b};
            ext_left = count_down(ext_left);
            phase = PH_ELEN_HI;
         end
         PH_ELEN_HI: begin
            fld_left = {b, 8'h00};
            ext_left = count_down(ext_left);
            phase = PH_ELEN_LO;
         end
         PH_ELEN_LO: begin
            fld_left = {fld_left[15:8], b};
            ext_left = count_down(ext_left);
            if (fld_left == 0) next_extension();
            else if (ext_acc == EXT_SERVER_NAME) phase = PH_SNI;
            else phase = PH_EXT_BODY;
         end
         PH_EXT_BODY: begin
            fld_left = count_down(fld_left);
            ext_left = count_down(ext_left);
            if (fld_left == 0) next_extension();
         end
         PH_SNI: begin
            // ext_acc counts list length, name type and name length bytes first
            if (ext_acc < SNI_HDR_BYTES) begin
               if (ext_acc == SNI_NAME_LEN_LO && {name_left[15:8], b} == 0) begin
                  end_parse(ST_FOUND);
               end else begin
                  if (ext_acc == SNI_NAME_LEN_HI) name_left = {b, 8'h00};
                  if (ext_acc == SNI_NAME_LEN_LO) name_left = {name_left[15:8], b};
                  ext_acc = ext_acc + 16'd1;
               end
            end else begin
               emit = (name_cnt < cfg_max_name);
               if (name_cnt != NAME_CNT_MAX) name_cnt = name_cnt + 8'd1;
               name_left = count_down(name_left);
               if (name_left == 0) end_parse(ST_FOUND);
            end
         end
         default: ;
      endcase
      if (emit || last) begin
         r.name_byte = emit ? b : 8'h00;
         r.has_name = emit;
         r.status = !last ? ST_FOUND : (done ? status_type'(ext_acc[2:0]) : ST_TRUNC);
         r.final_item = last;
         pending_sni_results.push_back(r);
      end
      if (last) clear_record_state();
   endfunction

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      sni_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sni_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual tdata %0h tuser %0h tlast %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_sni_results.pop_front();
            check_field("name_byte", want.name_byte, rsp_tdata);
            check_field("has_name_byte", want.has_name, rsp_tuser[0]);
            check_field("result_status", want.status, rsp_tuser[3:1]);
            check_field("final_item", want.final_item, rsp_tlast);
         end
      end
   end

   task automatic send_request(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      predict_sni_step(b, last);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_sni_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_HS_TYPE:   cfg_hs_type = value;
         REG_MAX_MINOR: cfg_max_minor = value;
         REG_MAX_NAME:  cfg_max_name = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_config(input logic [7:0] hs, input logic [7:0] minor,
                               input logic [7:0] name_max);
      wait_idle();
      csr_write(REG_HS_TYPE, hs);
      csr_write(REG_MAX_MINOR, minor);
      csr_write(REG_MAX_NAME, name_max);
   endtask

   function automatic void push_u16(ref logic [7:0] q[$], input logic [15:0] v);
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
   endfunction

   function automatic void add_other_extensions(ref logic [7:0] q[$], input int count);
      logic [15:0] ext_type;
      int body_len;
      for (int e = 0; e < count; e++) begin
         // nonzero types, some with only one byte set
         case ($urandom_range(2))
            0: ext_type = {8'h00, 8'($urandom_range(1, 255))};
            1: ext_type = {8'($urandom_range(1, 255)), 8'h00};
            default: ext_type = 16'($urandom_range(1, 65535));
         endcase
         body_len = $urandom_range(0, 6);
         push_u16(q, ext_type);
         push_u16(q, 16'(body_len));
         repeat (body_len) q.push_back(8'($urandom));
      end
   endfunction

   function automatic hello_t plain_hello();
      hello_t h;
      h.rec_type = cfg_hs_type;
      h.ver_major = TLS_MAJOR;
      h.ver_minor = cfg_max_minor;
      h.name_type = 8'h00;
      h.sid_len = 4;
      h.cs_len = 4;
      h.cm_len = 1;
      h.n_before = 1;
      h.n_after = 1;
      h.name_len = 6;
      h.trailing = 0;
      h.cut = 0;
      h.ext_len = -1;
      h.zero_sni = 1'b0;
      h.has_sni = 1'b1;
      return h;
   endfunction

   task automatic send_hello(input hello_t h);
      logic [7:0] exts[$];
      logic [7:0] rec[$];
      int ext_len;
      add_other_extensions(exts, h.n_before);
      if (h.zero_sni) repeat (4) exts.push_back(8'h00);
      if (h.has_sni) begin
         push_u16(exts, EXT_SERVER_NAME);
         push_u16(exts, 16'(h.name_len + 5));
         push_u16(exts, 16'(h.name_len + 3));
         exts.push_back(h.name_type);
         push_u16(exts, 16'(h.name_len));
         repeat (h.name_len) exts.push_back(8'($urandom));
      end
      add_other_extensions(exts, h.n_after);
      ext_len = (h.ext_len < 0) ? exts.size() : h.ext_len;
      rec.push_back(h.rec_type);
      push_u16(rec, 16'h0301);
      push_u16(rec, 16'($urandom));
      rec.push_back(8'h01);
      rec.push_back(8'h00);
      push_u16(rec, 16'($urandom));
      rec.push_back(h.ver_major);
      rec.push_back(h.ver_minor);
      repeat (32) rec.push_back(8'($urandom));
      rec.push_back(8'(h.sid_len));
      repeat (h.sid_len) rec.push_back(8'($urandom));
      push_u16(rec, 16'(h.cs_len));
      repeat (h.cs_len) rec.push_back(8'($urandom));
      rec.push_back(8'(h.cm_len));
      repeat (h.cm_len) rec.push_back(8'($urandom));
      push_u16(rec, 16'(ext_len));
      foreach (exts[k]) rec.push_back(exts[k]);
      repeat (h.trailing) rec.push_back(8'($urandom));
      if (h.cut > 0) while (rec.size() > h.cut) void'(rec.pop_back());
      foreach (rec[i]) send_request(rec[i], i == rec.size() - 1);
   endtask

   function automatic hello_t random_hello();
      hello_t h;
      int pick;
      h = plain_hello();
      h.sid_len = ($urandom_range(3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 2);
      h.cs_len = ($urandom_range(15) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
      h.cm_len = $urandom_range(0, 2);
      h.n_before = $urandom_range(0, 2);
      h.n_after = $urandom_range(0, 2);
      h.zero_sni = ($urandom_range(5) == 0);
      h.has_sni = ($urandom_range(7) != 0);
      h.name_len = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h.name_type = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
      h.ver_minor = 8'($urandom_range(0, cfg_max_minor));
      h.trailing = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
      pick = $urandom_range(99);
      if (pick < 8) begin
         h.rec_type = cfg_hs_type ^ 8'($urandom_range(1, 255));
      end else if (pick < 16) begin
         if (cfg_max_minor != 8'hFF && $urandom_range(1) == 1)
            h.ver_minor = 8'($urandom_range(cfg_max_minor + 1, 255));
         else
            h.ver_major = TLS_MAJOR ^ 8'($urandom_range(1, 255));
      end else if (pick < 30) begin
         h.cut = $urandom_range(1, 90);
      end else if (pick < 38) begin
         h.ext_len = $urandom_range(0, 30);
      end
      return h;
   endfunction

   task automatic test_record_type();
      hello_t h;
      // reset values are still in place here
      h = plain_hello();
      send_hello(h);
      h.rec_type = 8'd23;
      h.trailing = 3;
      send_hello(h);
      h = plain_hello();
      h.cut = 1;
      send_hello(h);
      write_config(8'd0, RST_MAX_MINOR, RST_MAX_NAME);
      h = plain_hello();
      send_hello(h);
      h.rec_type = 8'd255;
      h.cut = 1;
      send_hello(h);
      write_config(8'd255, RST_MAX_MINOR, RST_MAX_NAME);
      h = plain_hello();
      send_hello(h);
      h.rec_type = 8'd0;
      send_hello(h);
   endtask

   task automatic test_version_check();
      hello_t h;
      write_config(RST_HS_TYPE, 8'd0, RST_MAX_NAME);
      h = plain_hello();
      send_hello(h);
      h.ver_minor = 8'd1;
      send_hello(h);
      h = plain_hello();
      h.ver_major = 8'd2;
      send_hello(h);
      h.ver_major = 8'd4;
      send_hello(h);
      write_config(RST_HS_TYPE, 8'd255, RST_MAX_NAME);
      h = plain_hello();
      send_hello(h);
      // record ends on the minor version byte with a bad major
      h.ver_major = 8'd0;
      h.cut = 11;
      send_hello(h);
   endtask

   task automatic test_name_found();
      hello_t h;
      write_config(RST_HS_TYPE, RST_MAX_MINOR, RST_MAX_NAME);
      h = plain_hello();
      h.name_len = 0;
      send_hello(h);
      h = plain_hello();
      h.zero_sni = 1'b1;
      h.name_type = 8'hFF;
      h.n_before = 3;
      h.trailing = 5;
      send_hello(h);
      // last name byte carries the record end
      h = plain_hello();
      h.n_after = 0;
      h.name_len = 1;
      send_hello(h);
      write_config(RST_HS_TYPE, RST_MAX_MINOR, 8'd1);
      h = plain_hello();
      send_hello(h);
      write_config(RST_HS_TYPE, RST_MAX_MINOR, 8'd3);
      h = plain_hello();
      h.n_after = 0;
      h.name_len = 3;
      send_hello(h);
      h.name_len = 10;
      send_hello(h);
   endtask

   task automatic test_not_found();
      hello_t h;
      write_config(RST_HS_TYPE, RST_MAX_MINOR, RST_MAX_NAME);
      h = plain_hello();
      h.has_sni = 1'b0;
      h.n_before = 0;
      h.n_after = 0;
      send_hello(h);
      h.n_before = 3;
      h.sid_len = 32;
      h.cs_len = 0;
      h.cm_len = 0;
      send_hello(h);
      h = plain_hello();
      h.has_sni = 1'b0;
      h.zero_sni = 1'b1;
      h.sid_len = 0;
      h.cs_len = 300;
      send_hello(h);
   endtask

   task automatic test_truncated();
      hello_t h;
      h = plain_hello();
      h.cut = 5;
      send_hello(h);
      h.cut = 44;
      send_hello(h);
      // 48 fixed and sid, 6 cs, 2 cm, 2 block length, 9 header: name starts at 67
      h = plain_hello();
      h.n_before = 0;
      h.name_len = 10;
      h.cut = 72;
      send_hello(h);
      h = plain_hello();
      h.has_sni = 1'b0;
      h.n_after = 0;
      h.ext_len = 40;
      send_hello(h);
   endtask

   task automatic test_stalled_receiver();
      hello_t h;
      int saved_pct;
      write_config(RST_HS_TYPE, RST_MAX_MINOR, RST_MAX_NAME);
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_cycles = 400;
      h = plain_hello();
      h.name_len = 200;
      send_hello(h);
      send_idle_pct = saved_pct;
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int budget);
      int start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (2) begin
         write_config($urandom_range(1) ? RST_HS_TYPE : 8'($urandom),
                      $urandom_range(1) ? 8'($urandom_range(3, 4)) : 8'($urandom),
                      $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255)));
         start = requests_sent;
         while (requests_sent - start < budget) send_hello(random_hello());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_hs_type = RST_HS_TYPE;
      cfg_max_minor = RST_MAX_MINOR;
      cfg_max_name = RST_MAX_NAME;
      clear_record_state();
      send_idle_pct = 36;
      recv_idle_pct = 70;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_record_type();
      test_version_check();
      test_name_found();
      test_not_found();
      test_truncated();
      test_stalled_receiver();
      test_random_traffic(36, 70, 150);
      test_random_traffic(70, 36, 150);
      test_random_traffic(0, 0, 150);

      wait_idle();
      if (mismatch_count == 0)
         $display("tls_client_hello_sni_extractor: match");
      else
         $display("tls_client_hello_sni_extractor: mismatch");
      $finish;
   end

endmodule

[tls_client_hello_sni_extractor.f]
src/tlssni_pkg.sv
src/tlssni_csr.sv
src/tlssni_parser.sv
src/tls_client_hello_sni_extractor.sv
bench/testbench.sv
